### src/bfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

   // request opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   // configuration register indexes
   localparam logic CSR_VERTEX_COUNT  = 1'b0;
   localparam logic CSR_SOURCE_VERTEX = 1'b1;

   // fixed field widths
   localparam int VTX_W  = 6;
   localparam int DIST_W = 6;
   localparam int ROW_W  = 64;
   localparam int CNT_W  = 7;

   // controller states
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_START    = 8'b0000_0010,
      ST_POP      = 8'b0000_0100,
      ST_ROW      = 8'b0000_1000,
      ST_LOAD     = 8'b0001_0000,
      ST_PUSH     = 8'b0010_0000,
      ST_EMIT_RD  = 8'b0100_0000,
      ST_EMIT_OUT = 8'b1000_0000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_row;   // write one adjacency row
      logic start;      // seed visited set and queue with the source
      logic pop;        // read queue head
      logic row_rd;     // read adjacency row of popped vertex
      logic fresh_ld;   // capture newly reached neighbors
      logic push;       // enqueue lowest fresh neighbor
      logic emit_rd;    // read distance of current result vertex
      logic emit_next;  // step to next result vertex
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic src_bad;
      logic q_empty;
      logic fresh_zero;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

### src/bfs_hop_distance.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    opcode, row_index, row_bits
// rsp_      out        rsp_valid/rsp_ready    vertex, distance, reachable, last
// csr_      in         csr_valid/csr_ready    index, wdata
//
// A load transfer writes one row; loads can stream back to back.
// A run seeds the queue, then per dequeued vertex does a queue read, a row read, a
// mask capture and an end-of-row check, plus a push per newly reached vertex, and a
// final empty-queue check, then a distance memory read and an output per result; a
// source at or above the count skips the search. Registered memory reads set these
// steps. Reset is synchronous; no memory clearing pass. Requests stall from a run's
// acceptance until its last result transfers; rsp_ready low holds the result.

module bfs_hop_distance #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_opcode,
   input  wire logic [bfs_pkg::VTX_W-1:0]   req_row_index,
   input  wire logic [bfs_pkg::ROW_W-1:0]   req_row_bits,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bfs_pkg::VTX_W-1:0]        rsp_vertex,
   output logic [bfs_pkg::DIST_W-1:0]       rsp_distance,
   output logic                             rsp_reachable,
   output logic                             rsp_last,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [bfs_pkg::CNT_W-1:0]   csr_wdata
);

   bfs_pkg::cmd_type    cmd;
   bfs_pkg::status_type status;

   // configuration writes always land
   assign csr_ready = 1'b1;

   bfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   bfs_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .csr_wr        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_vertex    (rsp_vertex),
      .rsp_distance  (rsp_distance),
      .rsp_reachable (rsp_reachable),
      .rsp_last      (rsp_last)
   );

   // requests and results never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a result is pending");

   // a run transfer blocks further requests
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == bfs_pkg::OP_RUN) |=> !req_ready)
      else $error("request accepted right after a run");

   // final result returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("not idle after last result");

   // each following result needs a distance read first
   a_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> !rsp_valid)
      else $error("result shown without distance read");

endmodule

`default_nettype wire

### src/bfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bfs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_opcode,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire bfs_pkg::status_type status,
   output bfs_pkg::cmd_type        cmd
);

   bfs_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bfs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == bfs_pkg::OP_RUN) begin
                  state_in = bfs_pkg::ST_START;
               end else begin
                  cmd.load_row = 1'b1;
               end
            end
         end
         bfs_pkg::ST_START: begin
            cmd.start = 1'b1;
            state_in  = status.src_bad ? bfs_pkg::ST_EMIT_RD : bfs_pkg::ST_POP;
         end
         bfs_pkg::ST_POP: begin
            if (status.q_empty) begin
               state_in = bfs_pkg::ST_EMIT_RD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = bfs_pkg::ST_ROW;
            end
         end
         bfs_pkg::ST_ROW: begin
            cmd.row_rd = 1'b1;
            state_in   = bfs_pkg::ST_LOAD;
         end
         bfs_pkg::ST_LOAD: begin
            cmd.fresh_ld = 1'b1;
            state_in     = bfs_pkg::ST_PUSH;
         end
         bfs_pkg::ST_PUSH: begin
            if (status.fresh_zero) begin
               state_in = bfs_pkg::ST_POP;
            end else begin
               cmd.push = 1'b1;
            end
         end
         bfs_pkg::ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = bfs_pkg::ST_EMIT_OUT;
         end
         bfs_pkg::ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.emit_last) begin
                  state_in = bfs_pkg::ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = bfs_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = bfs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/bfs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bfs_datapath #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bfs_pkg::cmd_type            cmd,
   output bfs_pkg::status_type              status,
   input  wire logic [bfs_pkg::VTX_W-1:0]   req_row_index,
   input  wire logic [bfs_pkg::ROW_W-1:0]   req_row_bits,
   input  wire logic                        csr_wr,
   input  wire logic                        csr_index,
   input  wire logic [bfs_pkg::CNT_W-1:0]   csr_wdata,
   output logic [bfs_pkg::VTX_W-1:0]        rsp_vertex,
   output logic [bfs_pkg::DIST_W-1:0]       rsp_distance,
   output logic                             rsp_reachable,
   output logic                             rsp_last
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int QW = AW + bfs_pkg::DIST_W;

   // memories
   logic [MAX_VERTICES-1:0]     adj_rows_ff [MAX_VERTICES];
   logic [bfs_pkg::DIST_W-1:0]  dist_mem_ff [MAX_VERTICES];
   logic [QW-1:0]               queue_ff    [MAX_VERTICES];

   // registered read data
   logic [MAX_VERTICES-1:0]     adj_rd_ff;
   logic [bfs_pkg::DIST_W-1:0]  dist_rd_ff;
   logic [QW-1:0]               q_rd_ff;

   // control registers
   logic [CW-1:0]               n_ff, n_in;
   logic [bfs_pkg::VTX_W-1:0]   src_ff, src_in;
   logic [MAX_VERTICES-1:0]     visited_ff, visited_in;
   logic [MAX_VERTICES-1:0]     fresh_ff, fresh_in;
   logic [CW-1:0]               head_ff, head_in;
   logic [CW-1:0]               tail_ff, tail_in;
   logic [AW-1:0]               emit_v_ff, emit_v_in;

   logic [MAX_VERTICES-1:0]     in_use;
   logic [MAX_VERTICES-1:0]     iso;
   logic [AW-1:0]               iso_idx;
   logic [MAX_VERTICES-1:0]     src_onehot;
   logic                        src_bad;
   logic [AW-1:0]               q_vtx;
   logic [bfs_pkg::DIST_W-1:0]  q_dist;
   logic [bfs_pkg::DIST_W-1:0]  next_dist;
   logic                        qw_en;
   logic [AW-1:0]               qw_addr;
   logic [AW-1:0]               qw_vtx;
   logic [bfs_pkg::DIST_W-1:0]  qw_dist;
   logic                        row_ok;

   // mask of vertices in use
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         in_use[i] = (CW'(i) < n_ff);
      end
   end

   // lowest fresh neighbor, one-hot and encoded
   assign iso = fresh_ff & (~fresh_ff + MAX_VERTICES'(1));
   always_comb begin
      iso_idx = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         iso_idx = iso_idx | (iso[i] ? AW'(i) : '0);
      end
   end

   assign src_bad    = ({1'b0, src_ff} >= bfs_pkg::CNT_W'(n_ff));
   assign src_onehot = MAX_VERTICES'(1) << src_ff[AW-1:0];
   assign q_vtx      = q_rd_ff[QW-1:bfs_pkg::DIST_W];
   assign q_dist     = q_rd_ff[bfs_pkg::DIST_W-1:0];
   assign next_dist  = q_dist + bfs_pkg::DIST_W'(1);
   assign row_ok     = (bfs_pkg::CNT_W'(req_row_index) < bfs_pkg::CNT_W'(MAX_VERTICES));

   // queue / distance write port: seed at start, neighbor on push
   assign qw_en   = (cmd.start && !src_bad) || cmd.push;
   assign qw_addr = cmd.start ? '0 : tail_ff[AW-1:0];
   assign qw_vtx  = cmd.start ? src_ff[AW-1:0] : iso_idx;
   assign qw_dist = cmd.start ? '0 : next_dist;

   // configuration, clamped vertex count
   always_comb begin
      n_in   = n_ff;
      src_in = src_ff;
      if (csr_wr) begin
         if (csr_index == bfs_pkg::CSR_VERTEX_COUNT) begin
            if (csr_wdata == '0) begin
               n_in = CW'(1);
            end else if (csr_wdata > bfs_pkg::CNT_W'(MAX_VERTICES)) begin
               n_in = CW'(MAX_VERTICES);
            end else begin
               n_in = CW'(csr_wdata);
            end
         end else begin
            src_in = csr_wdata[bfs_pkg::VTX_W-1:0];
         end
      end
   end

   // search state next values
   always_comb begin
      visited_in = visited_ff;
      fresh_in   = fresh_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      emit_v_in  = emit_v_ff;
      if (cmd.start) begin
         visited_in = src_bad ? '0 : src_onehot;
         head_in    = '0;
         tail_in    = src_bad ? '0 : CW'(1);
         emit_v_in  = '0;
      end
      if (cmd.pop) begin
         head_in = head_ff + CW'(1);
      end
      if (cmd.fresh_ld) begin
         fresh_in = adj_rd_ff & in_use & ~visited_ff;
      end
      if (cmd.push) begin
         visited_in = visited_ff | iso;
         fresh_in   = fresh_ff & ~iso;
         tail_in    = tail_ff + CW'(1);
      end
      if (cmd.emit_next) begin
         emit_v_in = emit_v_ff + AW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff       <= CW'(MAX_VERTICES);
         src_ff     <= '0;
         visited_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         emit_v_ff  <= '0;
      end else begin
         n_ff       <= n_in;
         src_ff     <= src_in;
         visited_ff <= visited_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         emit_v_ff  <= emit_v_in;
      end
   end

   // fresh mask is payload, loaded before use
   always_ff @(posedge clock) begin
      fresh_ff <= fresh_in;
   end

   // adjacency memory
   always_ff @(posedge clock) begin
      if (cmd.load_row && row_ok) begin
         adj_rows_ff[req_row_index[AW-1:0]] <= req_row_bits[MAX_VERTICES-1:0];
      end
      if (cmd.row_rd) begin
         adj_rd_ff <= adj_rows_ff[q_vtx];
      end
   end

   // queue memory
   always_ff @(posedge clock) begin
      if (qw_en) begin
         queue_ff[qw_addr] <= {qw_vtx, qw_dist};
      end
      if (cmd.pop) begin
         q_rd_ff <= queue_ff[head_ff[AW-1:0]];
      end
   end

   // distance memory
   always_ff @(posedge clock) begin
      if (qw_en) begin
         dist_mem_ff[qw_vtx] <= qw_dist;
      end
      if (cmd.emit_rd) begin
         dist_rd_ff <= dist_mem_ff[emit_v_ff];
      end
   end

   // status
   assign status.src_bad    = src_bad;
   assign status.q_empty    = (head_ff == tail_ff);
   assign status.fresh_zero = (fresh_ff == '0);
   assign status.emit_last  = ((CW'(emit_v_ff) + CW'(1)) == n_ff);

   // result fields
   assign rsp_vertex    = bfs_pkg::VTX_W'(emit_v_ff);
   assign rsp_reachable = visited_ff[emit_v_ff];
   assign rsp_distance  = rsp_reachable ? dist_rd_ff : '0;
   assign rsp_last      = status.emit_last;

endmodule

`default_nettype wire

### verif/bfs_hop_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels, predicts the hop
// distances of every search and compares them with the results.
module bfs_hop_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [bfs_pkg::VTX_W-1:0]    req_row_index,
   input  logic [bfs_pkg::ROW_W-1:0]    req_row_bits,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [bfs_pkg::VTX_W-1:0]    rsp_vertex,
   input  logic [bfs_pkg::DIST_W-1:0]   rsp_distance,
   input  logic                         rsp_reachable,
   input  logic                         rsp_last,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [bfs_pkg::CNT_W-1:0]    csr_wdata,
   output int                           pending,
   output int                           errors
);

   import bfs_pkg::*;

   localparam int NUM_VERT = 64;

   typedef struct packed {
      logic [VTX_W-1:0]  vertex;
      logic [DIST_W-1:0] distance;
      logic              reachable;
      logic              last;
   } hop_result_t;

   hop_result_t      hop_expected_q[$];
   logic [ROW_W-1:0] adj_rows [NUM_VERT];
   logic [CNT_W-1:0] vertex_count;
   logic [VTX_W-1:0] source_vertex;
   int               mismatches = 0;

   // breadth-first search from the current source; queues one result per vertex
   function automatic void predict_hops();
      int               n;
      int               head;
      int               tail;
      int               cur;
      logic [ROW_W-1:0] in_use;
      logic [ROW_W-1:0] visited;
      logic [ROW_W-1:0] fresh;
      logic [VTX_W-1:0] order_q [NUM_VERT];
      logic [DIST_W-1:0] hops [NUM_VERT];
      hop_result_t      res;
      n = (vertex_count == 0) ? 1 : ((vertex_count > NUM_VERT) ? NUM_VERT : int'(vertex_count));
      in_use = (n >= NUM_VERT) ? {ROW_W{1'b1}} : ((64'd1 << n) - 64'd1);
      visited = '0;
      head = 0;
      tail = 0;
      for (int i = 0; i < NUM_VERT; i++) hops[i] = '0;
      if (source_vertex < n) begin
         visited[source_vertex] = 1'b1;
         order_q[0] = source_vertex;
         tail = 1;
         while (head < tail) begin
            cur = order_q[head];
            head++;
            fresh = adj_rows[cur] & in_use & ~visited;
            // neighbors enter the queue in increasing index order
            for (int i = 0; i < n; i++) begin
               if (fresh[i]) begin
                  visited[i] = 1'b1;
                  hops[i] = hops[cur] + 1'b1;
                  order_q[tail] = VTX_W'(i);
                  tail++;
               end
            end
         end
      end
      for (int v = 0; v < n; v++) begin
         res.vertex    = VTX_W'(v);
         res.reachable = visited[v];
         res.distance  = visited[v] ? hops[v] : '0;
         res.last      = (v == n - 1);
         hop_expected_q.push_back(res);
      end
   endfunction

   always @(posedge clock) begin : monitor
      hop_result_t got;
      hop_result_t want;
      logic        bad;
      if (reset) begin
         vertex_count  = 7'd64;
         source_vertex = '0;
         hop_expected_q.delete();
         for (int i = 0; i < NUM_VERT; i++) adj_rows[i] = '0;
      end else begin
         // result transfer: compare with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got.vertex    = rsp_vertex;
            got.distance  = rsp_distance;
            got.reachable = rsp_reachable;
            got.last      = rsp_last;
            if (hop_expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected result: vertex %0d distance %0d reachable %b last %b",
                           $realtime, got.vertex, got.distance, got.reachable, got.last);
            end else begin
               want = hop_expected_q.pop_front();
               bad = (got.vertex !== want.vertex) || (got.distance !== want.distance) ||
                     (got.reachable !== want.reachable) || (got.last !== want.last);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t mismatch: exp v=%0d d=%0d r=%b l=%b, got v=%0d d=%0d r=%b l=%b",
                              $realtime, want.vertex, want.distance, want.reachable, want.last,
                              got.vertex, got.distance, got.reachable, got.last);
               end
            end
         end
         // register write
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VERTEX_COUNT)
               vertex_count = csr_wdata;
            else
               source_vertex = csr_wdata[VTX_W-1:0];
         end
         // request transfer
         if (req_valid && req_ready) begin
            if (req_opcode == OP_LOAD)
               adj_rows[req_row_index] = req_row_bits;
            else
               predict_hops();
         end
      end
      pending <= hop_expected_q.size();
      errors  <= mismatches;
   end

endmodule

### verif/tb_bfs_hop_distance.sv
`timescale 1ns / 1ps

module tb_bfs_hop_distance;

   import bfs_pkg::*;

   localparam int ITEM_TARGET = 250;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int SETTLE      = 8;
   localparam int LONG_HOLD   = 600;

   typedef enum int {
      GRAPH_SPARSE,
      GRAPH_DENSE,
      GRAPH_CHAIN,
      GRAPH_EMPTY
   } graph_style_e;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_opcode;
   logic [VTX_W-1:0]   req_row_index;
   logic [ROW_W-1:0]   req_row_bits;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [VTX_W-1:0]   rsp_vertex;
   logic [DIST_W-1:0]  rsp_distance;
   logic               rsp_reachable;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [CNT_W-1:0]   csr_wdata;

   int                 fail_count;
   int                 hops_pending;
   int                 items_sent = 0;
   int                 hold_requests = 0;
   bit                 steady = 1'b0;
   logic [63:0]        loaded_rows = '0;

   bfs_hop_distance dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_vertex    (rsp_vertex),
      .rsp_distance  (rsp_distance),
      .rsp_reachable (rsp_reachable),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   bfs_hop_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_vertex    (rsp_vertex),
      .rsp_distance  (rsp_distance),
      .rsp_reachable (rsp_reachable),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending       (hops_pending),
      .errors        (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ROW_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // one adjacency row in the given style, with stray bits above the count at times
   function automatic logic [ROW_W-1:0] make_row(graph_style_e style, int r, int n);
      logic [ROW_W-1:0] in_use;
      logic [ROW_W-1:0] bits;
      logic [ROW_W-1:0] stray;
      in_use = (n >= 64) ? {ROW_W{1'b1}} : ((64'd1 << n) - 64'd1);
      stray = ($urandom_range(0, 1) != 0) ? (rand64() & ~in_use) : '0;
      case (style)
         GRAPH_SPARSE: begin
            bits = '0;
            repeat ($urandom_range(0, 2)) bits[$urandom_range(0, n - 1)] = 1'b1;
         end
         GRAPH_DENSE: bits = rand64();
         GRAPH_CHAIN: bits = (r + 1 < n) ? (64'd1 << (r + 1)) : '0;
         default: bits = '0;
      endcase
      return bits | stray;
   endfunction

   // result side: random ready, with a long hold-off on request
   initial begin
      int left;
      int holds_served;
      bit level;
      rsp_ready = 1'b0;
      left = 0;
      holds_served = 0;
      level = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            left = LONG_HOLD;
            level = 1'b0;
         end else if (left == 0) begin
            if (steady) begin
               level = 1'b1;
               left = 1;
            end else begin
               level = ($urandom_range(0, 2) != 0);
               left = pick_gap() + 1;
            end
         end
         rsp_ready <= level;
         left--;
      end
   end

   // one request transfer; valid stays up between back-to-back items
   task automatic send_req(input logic op, input logic [VTX_W-1:0] row,
                           input logic [ROW_W-1:0] bits);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_row_index <= row;
      req_row_bits  <= bits;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (op == OP_LOAD) loaded_rows[row] = 1'b1;
   endtask

   // block drained: no result outstanding and the last load has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (hops_pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CNT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CNT_W-1:0] vcount, input logic [VTX_W-1:0] src);
      wait_idle();
      if ($urandom_range(0, 1) != 0) begin
         csr_write(CSR_VERTEX_COUNT, vcount);
         csr_write(CSR_SOURCE_VERTEX, {1'b0, src});
      end else begin
         csr_write(CSR_SOURCE_VERTEX, {1'b0, src});
         csr_write(CSR_VERTEX_COUNT, vcount);
      end
   endtask

   initial begin
      logic [CNT_W-1:0] vcount;
      logic [VTX_W-1:0] src;
      graph_style_e     style;
      int               n;
      int               roll;
      int               phase;
      int               nseq;
      bit               reload;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_LOAD;
      req_row_index = '0;
      req_row_bits  = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_VERTEX_COUNT;
      csr_wdata     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: short path with stray bits above the count
      configure(7'd4, 6'd0);
      send_req(OP_LOAD, 6'd0, 64'hFFFF_FFFF_FFFF_FFF2);
      send_req(OP_LOAD, 6'd1, 64'h0000_0000_0000_0004);
      send_req(OP_LOAD, 6'd2, 64'h8000_0000_0000_0008);
      send_req(OP_LOAD, 6'd3, 64'h0);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
      // source with no outgoing edges
      configure(7'd4, 6'd3);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
      // source at or above the count: nothing reachable
      configure(7'd4, 6'd63);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
      // fully connected row
      configure(7'd4, 6'd2);
      send_req(OP_LOAD, 6'd2, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
      // single vertex, then a zero count
      configure(7'd1, 6'd0);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
      configure(7'd0, 6'd0);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
      configure(7'd2, 6'd1);
      send_req(OP_LOAD, 6'd1, 64'h0);
      send_req(OP_LOAD, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
      // top row index
      send_req(OP_LOAD, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
      configure(7'd4, 6'd0);
      send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());

      // random phases; the first is a full-length chain for the deepest distances,
      // the third always runs so the long receiver hold-off takes place
      phase = 0;
      while (items_sent < ITEM_TARGET || phase < 3) begin
         if (phase == 0) begin
            vcount = 7'd64;
            src = 6'd0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55)      vcount = CNT_W'($urandom_range(1, 8));
            else if (roll < 80) vcount = CNT_W'($urandom_range(9, 24));
            else if (roll < 90) vcount = 7'd64;
            else if (roll < 95) vcount = CNT_W'($urandom_range(25, 63));
            else if (roll < 97) vcount = 7'd0;
            else                vcount = CNT_W'($urandom_range(65, 127));
         end
         n = (vcount == 0) ? 1 : ((vcount > 64) ? 64 : int'(vcount));
         if (phase != 0)
            src = ($urandom_range(0, 6) != 0) ? VTX_W'($urandom_range(0, n - 1))
                                              : VTX_W'($urandom_range(0, 63));
         configure(vcount, src);
         steady <= (phase > 2) && ($urandom_range(0, 3) == 0);
         nseq = (phase == 2) ? 3 : ((phase == 0) ? 1 : $urandom_range(1, 3));
         for (int s = 0; s < nseq; s++) begin
            style = (phase == 0) ? GRAPH_CHAIN : graph_style_e'($urandom_range(0, 3));
            reload = (phase == 0) || ($urandom_range(0, 9) < ((n > 24) ? 3 : 7));
            // every row in use is loaded before the run
            for (int r = 0; r < n; r++)
               if (reload || !loaded_rows[r]) send_req(OP_LOAD, VTX_W'(r), make_row(style, r, n));
            if (phase != 0)
               repeat ($urandom_range(0, 2))
                  send_req(OP_LOAD, VTX_W'($urandom_range(0, 63)), rand64());
            // receiver holds off while more items keep coming
            if (phase == 2 && s == 0) hold_requests <= hold_requests + 1;
            send_req(OP_RUN, VTX_W'($urandom_range(0, 63)), rand64());
         end
         phase++;
      end

      wait_idle();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
